// ----- hw/rtl/fmrc_pkg.sv -----
// Shared types, constants and codes for the first-match rule classifier.
package fmrc_pkg;

  localparam int unsigned MAX_ENTRIES    = 64;
  localparam logic [7:0]  PROTO_WILDCARD = 8'd143;

  localparam int unsigned IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned HIT_W  = 6;
  localparam int unsigned HELD_W = 7;

  localparam int unsigned IN_FIELDS_W = 178;
  localparam int unsigned IN_DATA_W   = 184;
  localparam int unsigned IN_USER_W   = 2;
  localparam int unsigned OUT_DATA_W  = 16;
  localparam int unsigned OUT_USER_W  = 3;

  localparam logic [7:0] PROTO_TCP    = 8'd6;
  localparam logic [7:0] PROTO_UDP    = 8'd17;
  localparam logic [7:0] PROTO_ICMP   = 8'd1;
  localparam logic [3:0] IPV6_VERSION = 4'd6;
  localparam logic [2:0] XMAS_FLAGS   = 3'b111;
  localparam logic [1:0] ACK_ANY      = 2'd2;

  typedef enum logic [1:0] {
    MODE_ADD      = 2'd0,
    MODE_CLEAR    = 2'd1,
    MODE_CLASSIFY = 2'd2,
    MODE_RSVD     = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    OUT_HIT          = 3'd0,
    OUT_DEFAULT_DROP = 3'd1,
    OUT_XMAS         = 3'd2,
    OUT_IRRELEVANT   = 3'd3,
    OUT_REJECTED     = 3'd4,
    OUT_DONE         = 3'd5
  } outcome_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  // Input fields as packed in tdata, lowest field last in this list.
  typedef struct packed {
    logic [2:0]  tcp_flags;
    logic [3:0]  ip_version;
    logic        rule_action;
    logic [1:0]  ack_value;
    logic [15:0] dport;
    logic [15:0] sport;
    logic [7:0]  proto;
    logic [31:0] dst_mask;
    logic [31:0] dst_addr;
    logic [31:0] src_mask;
    logic [31:0] src_addr;
  } item_t;

  // One stored rule.
  typedef struct packed {
    logic        action;
    logic [1:0]  ack;
    logic [15:0] dport;
    logic [15:0] sport;
    logic [7:0]  proto;
    logic [31:0] dst_mask;
    logic [31:0] dst_net;
    logic [31:0] src_mask;
    logic [31:0] src_net;
  } rule_t;

  typedef struct packed {
    logic     capture;
    logic     write_rule;
    logic     clear;
    logic     scan_start;
    logic     scan_step;
    logic     set_res;
    outcome_e res_code;
    logic     load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  full;
    logic  xmas;
    logic  irrelevant;
    logic  hit;
    logic  scan_end;
    logic  out_free;
  } dp_sts_t;

endpackage

// ----- hw/rtl/first_match_rule_classifier_unit.sv -----
// First-match rule classifier: add rules, clear the table, classify packets.
//
// The slave channel takes one transaction per item: tuser carries the mode
// (add rule, clear table, classify packet) and tdata the rule or packet fields.
// Every item gives exactly one result transaction on the master channel: tuser
// carries the outcome code, tdata the verdict, the hit index and the number
// of rules held after the item.
// Add, clear, the reserved mode and packets settled by the flag or protocol
// tests go from the decode state straight to the finish state, which loads
// the result into the output register. A packet that goes to the table scan
// reads one rule per cycle from the rule memory and stops at the first match;
// with no match it reads all n rules held (none for an empty table), up to 64.
// Items are worked on one at a time; the block is ready again in the cycle
// after the result is loaded into the output register, even if the receiver
// has not taken it.
// When the receiver stalls with a result still waiting, a finished result
// waits inside the block and no further item is accepted.
// Reset empties the table at once (rule count zero) and clears the output.
module first_match_rule_classifier_unit import fmrc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // src_addr, src_mask, dst_addr, dst_mask, proto, sport, dport,
  // ack_value, rule_action, ip_version, tcp_flags, zero fill
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // mode
  input  logic [IN_USER_W-1:0]  s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // verdict, hit_index, rules_held, zero fill
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // outcome
  output logic [OUT_USER_W-1:0] m_axis_tuser_o
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  fmrc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fmrc_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .m_tready_i (m_axis_tready_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule

// ----- hw/rtl/fmrc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module fmrc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/fmrc_datapath.sv -----
// Datapath: item capture, rule table, rule count, scan pipeline and output register.
module fmrc_datapath import fmrc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [IN_DATA_W-1:0]  s_tdata_i,
  input  logic [IN_USER_W-1:0]  s_tuser_i,
  input  logic                  m_tready_i,
  output logic                  m_tvalid_o,
  output logic [OUT_DATA_W-1:0] m_tdata_o,
  output logic [OUT_USER_W-1:0] m_tuser_o,
  input  ctrl_cmd_t             cmd_i,
  output dp_sts_t               sts_o
);

  item_t              item_q;
  mode_e              mode_q;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic               chk_vld_q, chk_vld_d;
  logic [IDX_W-1:0]   chk_idx_q, chk_idx_d;
  logic               res_verdict_q;
  outcome_e           res_code_q;
  logic [HIT_W-1:0]   res_hit_q;
  logic               out_vld_q, out_vld_d;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [OUT_USER_W-1:0] out_user_q;

  rule_t              wr_rule;
  rule_t              rd_rule;
  logic [$bits(rule_t)-1:0] rd_raw;
  logic               rd_en;
  logic               src_ok, dst_ok, proto_ok, sport_ok, dport_ok, ack_ok, match;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= item_t'(s_tdata_i[IN_FIELDS_W-1:0]);
      mode_q <= mode_e'(s_tuser_i);
    end
  end

  assign wr_rule = '{action:   item_q.rule_action,
                     ack:      item_q.ack_value,
                     dport:    item_q.dport,
                     sport:    item_q.sport,
                     proto:    item_q.proto,
                     dst_mask: item_q.dst_mask,
                     dst_net:  item_q.dst_addr,
                     src_mask: item_q.src_mask,
                     src_net:  item_q.src_addr};

  // The table is written at the fill count and read by the scan pointer.
  assign rd_en = cmd_i.scan_step && (rd_ptr_q < cnt_q);

  fmrc_ram #(
    .WIDTH ($bits(rule_t)),
    .DEPTH (MAX_ENTRIES)
  ) u_rule_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write_rule),
    .waddr_i (cnt_q[IDX_W-1:0]),
    .wdata_i (wr_rule),
    .re_i    (rd_en),
    .raddr_i (rd_ptr_q[IDX_W-1:0]),
    .rdata_o (rd_raw)
  );

  assign rd_rule = rule_t'(rd_raw);

  // Rule tests on the entry read in the previous cycle.
  always_comb begin
    src_ok   = (rd_rule.src_net == '0) ||
               ((item_q.src_addr & rd_rule.src_mask) == (rd_rule.src_net & rd_rule.src_mask));
    dst_ok   = (rd_rule.dst_net == '0) ||
               ((item_q.dst_addr & rd_rule.dst_mask) == (rd_rule.dst_net & rd_rule.dst_mask));
    proto_ok = (rd_rule.proto == PROTO_WILDCARD) || (rd_rule.proto == item_q.proto);
    sport_ok = (rd_rule.sport == '0) || (rd_rule.sport == item_q.sport);
    dport_ok = (rd_rule.dport == '0) || (rd_rule.dport == item_q.dport);
    ack_ok   = (rd_rule.ack == ACK_ANY) || (rd_rule.ack == {1'b0, item_q.ack_value[0]});
    match    = src_ok && dst_ok && proto_ok && sport_ok && dport_ok && ack_ok;
  end

  always_comb begin
    cnt_d     = cnt_q;
    rd_ptr_d  = rd_ptr_q;
    chk_vld_d = chk_vld_q;
    chk_idx_d = chk_idx_q;
    if (cmd_i.clear) begin
      cnt_d = '0;
    end else if (cmd_i.write_rule) begin
      cnt_d = cnt_q + 1'b1;
    end
    if (cmd_i.scan_start) begin
      rd_ptr_d  = '0;
      chk_vld_d = 1'b0;
    end else if (cmd_i.scan_step) begin
      chk_vld_d = rd_en;
      chk_idx_d = rd_ptr_q[IDX_W-1:0];
      if (rd_en) begin
        rd_ptr_d = rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      rd_ptr_q  <= '0;
      chk_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      rd_ptr_q  <= rd_ptr_d;
      chk_vld_q <= chk_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q <= chk_idx_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.set_res) begin
      res_code_q    <= cmd_i.res_code;
      res_verdict_q <= (cmd_i.res_code == OUT_IRRELEVANT) ||
                       ((cmd_i.res_code == OUT_HIT) && rd_rule.action);
      res_hit_q     <= (cmd_i.res_code == OUT_HIT) ? HIT_W'(chk_idx_q) : '0;
    end
  end

  // Output register: loaded only when empty or being drained in the same cycle.
  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_i.load_out) begin
      out_vld_d = 1'b1;
    end else if (m_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q <= OUT_DATA_W'({HELD_W'(cnt_q), res_hit_q, res_verdict_q});
      out_user_q <= res_code_q;
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = out_data_q;
  assign m_tuser_o  = out_user_q;

  always_comb begin
    sts_o.mode       = mode_q;
    sts_o.full       = (cnt_q >= CNT_W'(MAX_ENTRIES));
    sts_o.xmas       = ((item_q.tcp_flags & XMAS_FLAGS) == XMAS_FLAGS);
    sts_o.irrelevant = ((item_q.proto != PROTO_TCP) && (item_q.proto != PROTO_UDP) &&
                        (item_q.proto != PROTO_ICMP)) || (item_q.ip_version == IPV6_VERSION);
    sts_o.hit        = chk_vld_q && match;
    sts_o.scan_end   = !chk_vld_q && (rd_ptr_q >= cnt_q);
    sts_o.out_free   = !out_vld_q || m_tready_i;
  end

`ifndef NO_ASSERTIONS
  a_write_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write_rule |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("rule count did not advance after a rule write");

  a_chk_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.scan_step && chk_vld_q) |-> CNT_W'(chk_idx_q) < cnt_q)
    else $error("checked entry lies beyond the rule count");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_vld_q || m_tready_i))
    else $error("result loaded over an untaken result");
`endif

endmodule

// ----- hw/rtl/fmrc_ctrl.sv -----
// Controller state machine: sequences capture, table update, scan and result hand-off.
module fmrc_ctrl import fmrc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_tvalid_i,
  output logic      s_tready_o,
  input  dp_sts_t   sts_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.res_code = OUT_DONE;
    s_tready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd_o.set_res = 1'b1;
        state_d       = ST_FINISH;
        unique case (sts_i.mode)
          MODE_ADD: begin
            if (sts_i.full) begin
              cmd_o.res_code = OUT_REJECTED;
            end else begin
              cmd_o.write_rule = 1'b1;
            end
          end
          MODE_CLEAR: begin
            cmd_o.clear = 1'b1;
          end
          MODE_CLASSIFY: begin
            priority if (sts_i.xmas) begin
              cmd_o.res_code = OUT_XMAS;
            end else if (sts_i.irrelevant) begin
              cmd_o.res_code = OUT_IRRELEVANT;
            end else begin
              cmd_o.set_res    = 1'b0;
              cmd_o.scan_start = 1'b1;
              state_d          = ST_SCAN;
            end
          end
          default: begin
            cmd_o.res_code = OUT_DONE;
          end
        endcase
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        priority if (sts_i.hit) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = OUT_HIT;
          state_d        = ST_FINISH;
        end else if (sts_i.scan_end) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = OUT_DEFAULT_DROP;
          state_d        = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
